/* rtl/nglp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglp_pkg
// Shared types, constants and small lookup functions of the GLL position
// parser: payload structs, result codes, character codes and field widths.
// ----------------------------------------------------------------------------
package nglp_pkg;

  // Capture buffer size and derived byte-position width
  localparam int BUFFER_BYTES = 256;
  localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
  localparam int CFG_W        = 8;
  localparam int CMP_W        = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;

  // Coordinate digit store: integer part kept as degrees and minutes
  localparam int Q_W   = 10;   // degrees, up to 999
  localparam int R_W   = 7;    // whole minutes, up to 99
  localparam int F_W   = 17;   // five fraction digits of minutes
  localparam int UTC_W = 20;
  localparam int E7_W  = 31;

  localparam logic [Q_W-1:0]   Q_SAT   = Q_W'(999);
  localparam logic [R_W-1:0]   R_SAT   = R_W'(99);
  localparam logic [UTC_W-1:0] UTC_MAX = UTC_W'(999999);
  localparam logic [E7_W-1:0]  LAT_MAX = E7_W'(999999999);
  localparam logic [E7_W-1:0]  LON_MAX = E7_W'(1999999999);
  localparam logic [CFG_W-1:0] MIN_BYTES_RST = CFG_W'(50);

  // Result codes
  localparam logic [1:0] RC_OK          = 2'd0;
  localparam logic [1:0] RC_NO_SENTENCE = 2'd1;
  localparam logic [1:0] RC_TRUNCATED   = 2'd2;
  localparam logic [1:0] RC_EMPTY       = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  localparam logic [2:0] TAG_LEN = 3'd6;

  // Field numbers (commas counted)
  localparam logic [2:0] FLD_LAT    = 3'd1;
  localparam logic [2:0] FLD_LON    = 3'd3;
  localparam logic [2:0] FLD_UTC    = 3'd5;
  localparam logic [2:0] FLD_STATUS = 3'd6;
  localparam logic [2:0] FLD_MAX    = 3'd7;

  localparam logic [3:0] OFS_FIRST  = 4'd7;
  localparam logic [3:0] OFS_SECOND = 4'd8;
  localparam logic [3:0] OFS_SAT    = 4'd9;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } nglp_in_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [29:0] latitude_e7;
    logic [30:0] longitude_e7;
    logic [19:0] utc_hhmmss;
    logic        fix_active;
    logic        latitude_present;
    logic        longitude_present;
    logic        utc_present;
    logic        status_present;
  } nglp_out_t;

  // Result fields that need no conversion
  typedef struct packed {
    logic [1:0]       code;
    logic [UTC_W-1:0] utc;
    logic             fix;
    logic             lat_p;
    logic             lon_p;
    logic             utc_p;
    logic             st_p;
  } nglp_tail_t;

  // Per-buffer summary handed from the scanner to the conversion pipeline
  typedef struct packed {
    nglp_tail_t     tail;
    logic [Q_W-1:0] lat_q;
    logic [R_W-1:0] lat_r;
    logic [F_W-1:0] lat_f;
    logic [Q_W-1:0] lon_q;
    logic [R_W-1:0] lon_r;
    logic [F_W-1:0] lon_f;
  } nglp_sum_t;

  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = CH_G;
      3'd2:    c = CH_P;
      3'd3:    c = CH_G;
      3'd4:    c = CH_L;
      3'd5:    c = CH_L;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [13:0] frac_weight(input logic [2:0] idx);
    logic [13:0] w;
    case (idx)
      3'd0:    w = 14'd10000;
      3'd1:    w = 14'd1000;
      3'd2:    w = 14'd100;
      3'd3:    w = 14'd10;
      3'd4:    w = 14'd1;
      default: w = 14'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/nglp_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglp_scan
// Byte scanner: tag search, field counting and digit accumulation, one byte
// per beat; emits a registered summary on the last byte of each buffer.
// ----------------------------------------------------------------------------
module nglp_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  nglp_pkg::nglp_in_t       in_data,
  input  logic                     cfg_valid,
  input  logic [nglp_pkg::CFG_W-1:0] cfg_data,
  output logic                     sum_valid,
  input  logic                     sum_ready,
  output nglp_pkg::nglp_sum_t      sum_data
);
  import nglp_pkg::*;

  logic [CFG_W-1:0] min_bytes_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       mp_r, mp_nxt;
  logic             found_r, found_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [3:0]       ofs_r, ofs_nxt;
  logic             empty_r, empty_nxt;
  logic [2:0]       fld_r, fld_nxt;
  logic             stop_r, stop_nxt;
  logic [Q_W-1:0]   q_r [2], q_nxt [2];
  logic [R_W-1:0]   r_r [2], r_nxt [2];
  logic [F_W-1:0]   f_r [2], f_nxt [2];
  logic [2:0]       fd_r, fd_nxt;
  logic             infr_r, infr_nxt;
  logic [UTC_W-1:0] utc_r, utc_nxt;
  logic [4:0]       flags_r, flags_nxt;
  logic             dead_r, dead_nxt;
  logic             done_r, done_nxt;
  logic             fresh_r, fresh_nxt;

  logic             sum_v_r;
  nglp_sum_t        sum_r, sum_nxt;

  logic             accept;
  logic [7:0]       b;
  logic             digit;
  logic [3:0]       d;
  logic             slot;
  logic             slot_hit;
  logic [9:0]       tq;
  logic [3:0]       tq_div;
  logic [15:0]      tq_mul;
  logic [23:0]      utc_ext;
  logic [3:0]       ofs_inc;
  logic             code_ok;
  logic [CMP_W-1:0] need_end;

  assign in_ready  = ~sum_v_r | sum_ready;
  assign accept    = in_valid & in_ready;
  assign sum_valid = sum_v_r;
  assign sum_data  = sum_r;

  assign b     = in_data.rx_byte;
  assign digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign d     = 4'(b - CH_ZERO);
  assign slot  = (fld_r == FLD_LON);
  assign slot_hit = (fld_r == FLD_LAT) || (fld_r == FLD_LON);

  // Append a digit to degrees/minutes: t = r*10 + d, split by 100
  assign tq     = 10'(r_r[slot]) * 10'd10 + 10'(d);
  assign tq_mul = 16'(tq) * 16'd41;
  assign tq_div = 4'(tq_mul >> 12);
  assign utc_ext = 24'(utc_r) * 24'd10 + 24'(d);
  assign ofs_inc = (ofs_r < OFS_SAT) ? ofs_r + 4'd1 : ofs_r;

  always_comb begin
    pos_nxt   = pos_r;
    mp_nxt    = mp_r;
    found_nxt = found_r;
    start_nxt = start_r;
    ofs_nxt   = ofs_r;
    empty_nxt = empty_r;
    fld_nxt   = fld_r;
    stop_nxt  = stop_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    f_nxt     = f_r;
    fd_nxt    = fd_r;
    infr_nxt  = infr_r;
    utc_nxt   = utc_r;
    flags_nxt = flags_r;
    dead_nxt  = dead_r;
    done_nxt  = done_r;
    fresh_nxt = fresh_r;

    if (pos_r < POS_W'(BUFFER_BYTES)) begin
      pos_nxt = pos_r + POS_W'(1);
      if (found_r) begin
        ofs_nxt = ofs_inc;
        if (ofs_inc == OFS_FIRST) begin
          empty_nxt = (b == CH_COMMA);
        end else if (ofs_inc == OFS_SECOND) begin
          empty_nxt = empty_r && (b == CH_COMMA);
        end
        if (!stop_r) begin
          if (fresh_r && fld_r == FLD_STATUS && b == CH_A) begin
            flags_nxt[0] = 1'b1;
          end
          fresh_nxt = 1'b0;
          if (b == CH_STAR || b < CH_SPACE || b > CH_LOW_Z) begin
            stop_nxt = 1'b1;
          end else if (b == CH_COMMA) begin
            if (fld_r < FLD_MAX) begin
              fld_nxt = fld_r + 3'd1;
            end
            case (fld_nxt)
              FLD_LAT:    flags_nxt[1] = 1'b1;
              FLD_LON:    flags_nxt[2] = 1'b1;
              FLD_UTC:    flags_nxt[3] = 1'b1;
              FLD_STATUS: flags_nxt[4] = 1'b1;
              default:    ;
            endcase
            infr_nxt  = 1'b0;
            fd_nxt    = 3'd0;
            done_nxt  = 1'b0;
            fresh_nxt = 1'b1;
          end else if (!done_r) begin
            if (fld_r == FLD_UTC) begin
              if (digit) begin
                utc_nxt = (utc_ext > 24'(UTC_MAX)) ? UTC_MAX : utc_ext[UTC_W-1:0];
              end else begin
                done_nxt = 1'b1;
              end
            end else if (slot_hit) begin
              if (digit) begin
                if (!infr_r) begin
                  // Whole part saturates once it exceeds five digits
                  if (q_r[slot] >= Q_W'(100)) begin
                    q_nxt[slot] = Q_SAT;
                    r_nxt[slot] = R_SAT;
                  end else begin
                    q_nxt[slot] = Q_W'(q_r[slot] * Q_W'(10)) + Q_W'(tq_div);
                    r_nxt[slot] = R_W'(tq - 10'(tq_div) * 10'd100);
                  end
                end else if (fd_r < 3'd5) begin
                  f_nxt[slot] = f_r[slot] + F_W'(d) * F_W'(frac_weight(fd_r));
                  fd_nxt      = fd_r + 3'd1;
                end
              end else if (b == CH_DOT && !infr_r) begin
                infr_nxt = 1'b1;
              end else begin
                done_nxt = 1'b1;
              end
            end
          end
        end
      end else if (!dead_r) begin
        if (b == CH_NUL) begin
          dead_nxt = 1'b1;
        end else if (mp_r < TAG_LEN && b == tag_char(mp_r)) begin
          if (mp_r == 3'd0) begin
            start_nxt = pos_r;
          end
          mp_nxt = mp_r + 3'd1;
          if (mp_nxt == TAG_LEN) begin
            found_nxt = 1'b1;
            ofs_nxt   = 4'(TAG_LEN - 3'd1);
          end
        end else if (b == CH_DOLLAR) begin
          mp_nxt    = 3'd1;
          start_nxt = pos_r;
        end else begin
          mp_nxt = 3'd0;
        end
      end
    end
  end

  // Summary of the finished buffer
  assign need_end = CMP_W'(start_nxt) + CMP_W'(min_bytes_r);

  always_comb begin
    sum_nxt = '0;
    if (!found_nxt) begin
      sum_nxt.tail.code = RC_NO_SENTENCE;
    end else if (need_end > CMP_W'(pos_nxt)) begin
      sum_nxt.tail.code = RC_TRUNCATED;
    end else if (empty_nxt) begin
      sum_nxt.tail.code = RC_EMPTY;
    end else begin
      sum_nxt.tail.code = RC_OK;
    end
    code_ok = (sum_nxt.tail.code == RC_OK);
    if (code_ok) begin
      sum_nxt.tail.fix   = flags_nxt[0];
      sum_nxt.tail.lat_p = flags_nxt[1];
      sum_nxt.tail.lon_p = flags_nxt[2];
      sum_nxt.tail.utc_p = flags_nxt[3];
      sum_nxt.tail.st_p  = flags_nxt[4];
      if (flags_nxt[3]) begin
        sum_nxt.tail.utc = utc_nxt;
      end
      if (flags_nxt[1]) begin
        sum_nxt.lat_q = q_nxt[0];
        sum_nxt.lat_r = r_nxt[0];
        sum_nxt.lat_f = f_nxt[0];
      end
      if (flags_nxt[2]) begin
        sum_nxt.lon_q = q_nxt[1];
        sum_nxt.lon_r = r_nxt[1];
        sum_nxt.lon_f = f_nxt[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bytes_r <= MIN_BYTES_RST;
    end else if (cfg_valid) begin
      min_bytes_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.last_byte)) begin
      pos_r   <= '0;
      mp_r    <= '0;
      found_r <= 1'b0;
      start_r <= '0;
      ofs_r   <= '0;
      empty_r <= 1'b0;
      fld_r   <= '0;
      stop_r  <= 1'b0;
      q_r     <= '{default: '0};
      r_r     <= '{default: '0};
      f_r     <= '{default: '0};
      fd_r    <= '0;
      infr_r  <= 1'b0;
      utc_r   <= '0;
      flags_r <= '0;
      dead_r  <= 1'b0;
      done_r  <= 1'b0;
      fresh_r <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      mp_r    <= mp_nxt;
      found_r <= found_nxt;
      start_r <= start_nxt;
      ofs_r   <= ofs_nxt;
      empty_r <= empty_nxt;
      fld_r   <= fld_nxt;
      stop_r  <= stop_nxt;
      q_r     <= q_nxt;
      r_r     <= r_nxt;
      f_r     <= f_nxt;
      fd_r    <= fd_nxt;
      infr_r  <= infr_nxt;
      utc_r   <= utc_nxt;
      flags_r <= flags_nxt;
      dead_r  <= dead_nxt;
      done_r  <= done_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else if (accept && in_data.last_byte) begin
      sum_v_r <= 1'b1;
    end else if (sum_ready) begin
      sum_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_byte) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

/* rtl/nglp_e7.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nglp_e7
// Three-stage conversion of degrees, minutes and minute fraction into
// degrees times 1e7, saturated at a cap.
// ----------------------------------------------------------------------------
module nglp_e7 (
  input  logic                       clk,
  input  logic                       en1,
  input  logic                       en2,
  input  logic                       en3,
  input  logic [nglp_pkg::Q_W-1:0]   q_in,
  input  logic [nglp_pkg::R_W-1:0]   r_in,
  input  logic [nglp_pkg::F_W-1:0]   f_in,
  input  logic [nglp_pkg::E7_W-1:0]  cap,
  output logic [nglp_pkg::E7_W-1:0]  e7_out
);
  import nglp_pkg::*;

  // floor(x/3) = (x * RECIP3) >> 28 for x below 2^27
  localparam logic [26:0] RECIP3 = 27'd89478486;

  logic [25:0]     x_r, x_nxt;
  logic [33:0]     deg1_r, deg1_nxt;
  logic [33:0]     deg2_r;
  logic [52:0]     prod;
  logic [23:0]     quo_r;
  logic [33:0]     total;
  logic [E7_W-1:0] e7_r;

  // Minutes times 1e5 scaled by 5 (x100/60 = x5/3)
  assign x_nxt    = 26'(r_in) * 26'd500000 + 26'(f_in) * 26'd5;
  assign deg1_nxt = 34'(q_in) * 34'd10000000;
  assign prod     = 53'(x_r) * 53'(RECIP3);
  assign total    = deg2_r + 34'(quo_r);

  always_ff @(posedge clk) begin
    if (en1) begin
      x_r    <= x_nxt;
      deg1_r <= deg1_nxt;
    end
    if (en2) begin
      quo_r  <= prod[51:28];
      deg2_r <= deg1_r;
    end
    if (en3) begin
      e7_r <= (total > 34'(cap)) ? cap : total[E7_W-1:0];
    end
  end

  assign e7_out = e7_r;

endmodule

/* rtl/nmea_gpgll_position_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gpgll_position_parser_unit
// GLL sentence parser: bytes of one captured buffer in, one position result
// out per buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one buffer byte per beat; last_byte marks the final byte of the
//            buffer. Bytes past the buffer size are dropped, but last_byte
//            still closes the buffer.
//   out_*  : exactly one result beat per buffer, carrying the result code,
//            latitude/longitude in degrees x 1e7, UTC hhmmss, fix and
//            presence flags. Every field but the code is zero on an error.
//   cfg_*  : writes min_sentence_bytes; cfg_ready is always high. Write only
//            while no buffer is in progress or in flight.
// Throughput: one byte per cycle, sustained while out_ready stays high, including the
//   last byte of one buffer followed directly by the first byte of the next.
// Pipeline: after the last byte is accepted the buffer summary is registered,
//   then passes through the coordinate conversion pipeline (a multiply stage, a
//   divide-by-3 reciprocal multiply stage and a saturating add stage).
// Reset: synchronous, active low; clears the scanner and all pipeline valids
//   and restores min_sentence_bytes to 50.
// Stall: when out_ready is low the pipeline fills and holds; in_ready drops
//   only once a buffer summary cannot move on.
// ----------------------------------------------------------------------------
module nmea_gpgll_position_parser_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  nglp_pkg::nglp_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nglp_pkg::nglp_out_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [nglp_pkg::CFG_W-1:0]  cfg_data
);
  import nglp_pkg::*;

  logic       sum_valid;
  nglp_sum_t  sum_data;

  // Pipeline valids and stage-advance terms
  logic       v1_r, v2_r, v3_r;
  logic       rdy1, rdy2, rdy3;
  nglp_tail_t tail1_r, tail2_r, tail3_r;

  logic [E7_W-1:0] lat_e7;
  logic [E7_W-1:0] lon_e7;

  assign cfg_ready = 1'b1;

  // A stage loads whenever it is empty or its contents move on this cycle
  assign rdy3 = ~v3_r | out_ready;
  assign rdy2 = ~v2_r | rdy3;
  assign rdy1 = ~v1_r | rdy2;

  nglp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .sum_valid (sum_valid),
    .sum_ready (rdy1),
    .sum_data  (sum_data)
  );

  nglp_e7 u_lat (
    .clk    (clk),
    .en1    (rdy1),
    .en2    (rdy2),
    .en3    (rdy3),
    .q_in   (sum_data.lat_q),
    .r_in   (sum_data.lat_r),
    .f_in   (sum_data.lat_f),
    .cap    (LAT_MAX),
    .e7_out (lat_e7)
  );

  nglp_e7 u_lon (
    .clk    (clk),
    .en1    (rdy1),
    .en2    (rdy2),
    .en3    (rdy3),
    .q_in   (sum_data.lon_q),
    .r_in   (sum_data.lon_r),
    .f_in   (sum_data.lon_f),
    .cap    (LON_MAX),
    .e7_out (lon_e7)
  );

  // Advance valids alongside the conversion datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= sum_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Carry the unconverted fields with the beat
  always_ff @(posedge clk) begin
    if (rdy1) begin
      tail1_r <= sum_data.tail;
    end
    if (rdy2) begin
      tail2_r <= tail1_r;
    end
    if (rdy3) begin
      tail3_r <= tail2_r;
    end
  end

  assign out_valid = v3_r;

  always_comb begin
    out_data.result_code       = tail3_r.code;
    out_data.latitude_e7       = lat_e7[29:0];
    out_data.longitude_e7      = lon_e7[30:0];
    out_data.utc_hhmmss        = tail3_r.utc;
    out_data.fix_active        = tail3_r.fix;
    out_data.latitude_present  = tail3_r.lat_p;
    out_data.longitude_present = tail3_r.lon_p;
    out_data.utc_present       = tail3_r.utc_p;
    out_data.status_present    = tail3_r.st_p;
  end

endmodule
